FILE: rtl/spas_pkg.sv
// Shared definitions for the spring animation stepper.
// Widths, fixed-point constants, datapath operation codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package spas_pkg;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int PROG_W  = 17;
	localparam int QUOT_W  = 16;

	// Shared multiplier operand and product widths
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Input command kinds
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_TENSION  = 2'd0;
	localparam logic [1:0] REG_DAMPING  = 2'd1;
	localparam logic [1:0] REG_DURATION = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] TENSION_RST  = 16'd60293;
	localparam logic [CFG_W-1:0] DAMPING_RST  = 16'd49152;
	localparam logic [CFG_W-1:0] DURATION_RST = 16'd300;

	// Fixed-point constants: 0.016 s step in Q0.16, one in Q1.16, 3.0 in Q2.16
	localparam logic [MUL_B_W-1:0] STEP_Q16  = 19'd1049;
	localparam logic [PROG_W-1:0]  ONE_Q16   = 17'd65536;
	localparam logic [17:0]        THREE_Q16 = 18'd196608;

	// Datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_START    = 4'd1;
	localparam logic [3:0] OP_SNAP     = 4'd2;
	localparam logic [3:0] OP_M_TEN    = 4'd3;
	localparam logic [3:0] OP_M_DAMP   = 4'd4;
	localparam logic [3:0] OP_ACCEL    = 4'd5;
	localparam logic [3:0] OP_M_ACC    = 4'd6;
	localparam logic [3:0] OP_SPEED    = 4'd7;
	localparam logic [3:0] OP_M_SPD    = 4'd8;
	localparam logic [3:0] OP_VALUE    = 4'd9;
	localparam logic [3:0] OP_M_TT     = 4'd10;
	localparam logic [3:0] OP_M_SMOOTH = 4'd11;
	localparam logic [3:0] OP_PROG     = 4'd12;

	typedef struct packed {
		logic       ld_in;
		logic [3:0] op;
		logic       div_start;
		logic       ld_out;
	} spas_cmd_t;

	typedef struct packed {
		logic cmd_tick;
		logic running;
		logic finished;
		logic div_busy;
	} spas_stat_t;

endpackage

`default_nettype wire

FILE: rtl/spring_animation_step.sv
// Spring animation stepper, top level: streaming ports, controller and
// datapath. Uses spas_pkg, spas_ctrl, spas_dp.
//
// Takes one item at a time and returns exactly one result item per input
// item. A start command, a tick while idle and a tick that ends the
// animation go from acceptance through the evaluate state to the done
// state, which loads the result register; a tick that takes a spring step
// runs the bit-serial divider that forms elapsed/duration beside the spring
// multiplications on the single shared 36x19 multiplier. A new item is
// accepted while an earlier result still waits in the output register.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// and must only change while the block is idle.
`default_nettype none

module spring_animation_step
	import spas_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [95:0]        s_tdata,   // time_ms, start_value, goal_value
	input  wire logic               s_tuser,   // cmd
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [55:0]             m_tdata    // value_out, progress_out, running_out
);

	spas_cmd_t           ctl;
	spas_stat_t          stat;
	logic [VALUE_W-1:0]  out_value;
	logic [PROG_W-1:0]   out_progress;
	logic                out_running;

	spas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	spas_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_cmd       (s_tuser),
		.in_time      (s_tdata[31:0]),
		.in_start     (s_tdata[63:32]),
		.in_goal      (s_tdata[95:64]),
		.ctl          (ctl),
		.stat         (stat),
		.out_value    (out_value),
		.out_progress (out_progress),
		.out_running  (out_running)
	);

	// Pack the result item
	assign m_tdata = {6'b0, out_running, out_progress, out_value};

	// An accepted item closes the input until its result is registered
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// The divider only runs inside a spring step
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !s_tready && !ctl.ld_out)
		else $error("divider busy outside a spring step");

	// Progress never exceeds one
	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[48:32] <= ONE_Q16))
		else $error("progress out of range");

	// A result is loaded only once per accepted item
	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |=> !ctl.ld_out)
		else $error("result loaded twice");

endmodule

`default_nettype wire

FILE: rtl/spas_div.sv
// Restoring divider for the progress ratio: elapsed * 65536 / duration.
// One quotient bit per cycle, sixteen quotient bits. Uses spas_pkg.
`default_nettype none

module spas_div
	import spas_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CFG_W-1:0]  dividend,
	input  wire logic [CFG_W-1:0]  divisor,
	output logic                   busy,
	output logic [QUOT_W-1:0]      quot
);

	logic [CFG_W-1:0]  rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic [CFG_W:0]    shifted;
	logic [CFG_W:0]    diff;
	logic              fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, divisor};
		fits    = (shifted >= {1'b0, divisor});
	end

	// Sequence the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

FILE: rtl/spas_dp.sv
// Datapath: configuration, animation state, one shared multiplier,
// the progress divider and the result register. Uses spas_pkg, spas_div.
`default_nettype none

module spas_dp
	import spas_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_cmd,
	input  wire logic [TIME_W-1:0]  in_time,
	input  wire logic [VALUE_W-1:0] in_start,
	input  wire logic [VALUE_W-1:0] in_goal,
	input  wire spas_cmd_t          ctl,
	output spas_stat_t              stat,
	output logic [VALUE_W-1:0]      out_value,
	output logic [PROG_W-1:0]       out_progress,
	output logic                    out_running
);

	localparam logic signed [39:0] SAT_MAX = 40'sh007FFFFFFF;
	localparam logic signed [39:0] SAT_MIN = 40'shFF80000000;

	// Q0.16 product rounding, ties toward plus infinity
	function automatic logic signed [38:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] s;
		s = p + 55'sd32768;
		return s[PROD_W-1:16];
	endfunction

	// Clamp to the signed value range
	function automatic logic signed [VALUE_W-1:0] sat(input logic signed [39:0] x);
		logic signed [VALUE_W-1:0] r;
		if (x > SAT_MAX) begin
			r = SAT_MAX[VALUE_W-1:0];
		end else if (x < SAT_MIN) begin
			r = SAT_MIN[VALUE_W-1:0];
		end else begin
			r = x[VALUE_W-1:0];
		end
		return r;
	endfunction

	logic [CFG_W-1:0]          tension_q, damping_q, duration_q;
	logic                      in_cmd_q;
	logic [TIME_W-1:0]         in_time_q;
	logic [VALUE_W-1:0]        in_start_q, in_goal_q;
	logic signed [VALUE_W-1:0] value_q, speed_q, goal_q;
	logic [TIME_W-1:0]         begin_q;
	logic                      running_q;
	logic [PROG_W-1:0]         progress_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MUL_A_W-1:0] term1_q, accel_q;
	logic [VALUE_W-1:0]        out_value_q;
	logic [PROG_W-1:0]         out_prog_q;
	logic                      out_run_q;

	logic [TIME_W-1:0]         elapsed;
	logic                      finished;
	logic                      div_busy;
	logic [QUOT_W-1:0]         quot;
	logic signed [32:0]        diff_gv;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [38:0]        prod_r;
	logic [17:0]               smooth_s;
	logic [PROD_W-1:0]         prog_sum;
	logic [18:0]               prog_raw;
	logic signed [39:0]        speed_sum, value_sum;

	// Configuration writes; an unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q  <= TENSION_RST;
			damping_q  <= DAMPING_RST;
			duration_q <= DURATION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TENSION:  tension_q  <= cfg_data;
				REG_DAMPING:  damping_q  <= cfg_data;
				REG_DURATION: duration_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			in_cmd_q   <= in_cmd;
			in_time_q  <= in_time;
			in_start_q <= in_start;
			in_goal_q  <= in_goal;
		end
	end

	// Elapsed time with wrapping subtraction
	always_comb begin
		elapsed  = in_time_q - begin_q;
		finished = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, duration_q});
	end

	spas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (elapsed[CFG_W-1:0]),
		.divisor  (duration_q),
		.busy     (div_busy),
		.quot     (quot)
	);

	// Shared multiplier operand selection
	always_comb begin
		diff_gv  = {goal_q[VALUE_W-1], goal_q} - {value_q[VALUE_W-1], value_q};
		smooth_s = THREE_Q16 - {1'b0, quot, 1'b0};
		mul_a    = '0;
		mul_b    = '0;
		case (ctl.op)
			OP_M_TEN: begin
				mul_a = {{3{diff_gv[32]}}, diff_gv};
				mul_b = {3'b0, tension_q};
			end
			OP_M_DAMP: begin
				mul_a = {{4{speed_q[VALUE_W-1]}}, speed_q};
				mul_b = {3'b0, damping_q};
			end
			OP_M_ACC: begin
				mul_a = accel_q;
				mul_b = STEP_Q16;
			end
			OP_M_SPD: begin
				mul_a = {{4{speed_q[VALUE_W-1]}}, speed_q};
				mul_b = STEP_Q16;
			end
			OP_M_TT: begin
				mul_a = {20'b0, quot};
				mul_b = {3'b0, quot};
			end
			OP_M_SMOOTH: begin
				mul_a = {4'b0, prod_q[31:0]};
				mul_b = {1'b0, smooth_s};
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// Rounded product, updated speed and value, eased progress
	always_comb begin
		prod_r    = rnd16(prod_q);
		speed_sum = {{8{speed_q[VALUE_W-1]}}, speed_q} + {prod_r[38], prod_r};
		value_sum = {{8{value_q[VALUE_W-1]}}, value_q} + {prod_r[38], prod_r};
		prog_sum  = prod_q + 55'sh80000000;
		prog_raw  = prog_sum[50:32];
	end

	// Product and intermediate terms
	always_ff @(posedge clk) begin
		if (ctl.op inside {OP_M_TEN, OP_M_DAMP, OP_M_ACC, OP_M_SPD, OP_M_TT,
				OP_M_SMOOTH}) begin
			prod_q <= mul_p;
		end
		if (ctl.op == OP_M_DAMP) begin
			term1_q <= prod_r[MUL_A_W-1:0];
		end
		if (ctl.op == OP_ACCEL) begin
			accel_q <= term1_q - prod_r[MUL_A_W-1:0];
		end
	end

	// Animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q    <= '0;
			speed_q    <= '0;
			goal_q     <= '0;
			begin_q    <= '0;
			running_q  <= 1'b0;
			progress_q <= '0;
		end else begin
			case (ctl.op)
				OP_START: begin
					value_q    <= in_start_q;
					goal_q     <= in_goal_q;
					begin_q    <= in_time_q;
					speed_q    <= '0;
					running_q  <= 1'b1;
					progress_q <= '0;
				end
				OP_SNAP: begin
					value_q    <= goal_q;
					progress_q <= ONE_Q16;
					running_q  <= 1'b0;
				end
				OP_SPEED: speed_q <= sat(speed_sum);
				OP_VALUE: value_q <= sat(value_sum);
				OP_PROG: begin
					progress_q <= (prog_raw > {2'b0, ONE_Q16}) ? ONE_Q16
						: prog_raw[PROG_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			out_value_q <= value_q;
			out_prog_q  <= progress_q;
			out_run_q   <= running_q;
		end
	end

	always_comb begin
		stat.cmd_tick = (in_cmd_q == CMD_TICK);
		stat.running  = running_q;
		stat.finished = finished;
		stat.div_busy = div_busy;
	end

	assign out_value    = out_value_q;
	assign out_progress = out_prog_q;
	assign out_running  = out_run_q;

endmodule

`default_nettype wire

FILE: rtl/spas_ctrl.sv
// Controller state machine: sequences the datapath operations for one
// item and owns the output valid flag. Uses spas_pkg.
`default_nettype none

module spas_ctrl
	import spas_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire spas_stat_t stat,
	output spas_cmd_t       ctl
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_EVAL     = 4'd1;
	localparam logic [3:0] ST_M_DAMP   = 4'd2;
	localparam logic [3:0] ST_ACCEL    = 4'd3;
	localparam logic [3:0] ST_M_ACC    = 4'd4;
	localparam logic [3:0] ST_SPEED    = 4'd5;
	localparam logic [3:0] ST_M_SPD    = 4'd6;
	localparam logic [3:0] ST_VALUE    = 4'd7;
	localparam logic [3:0] ST_WAIT_DIV = 4'd8;
	localparam logic [3:0] ST_M_SMOOTH = 4'd9;
	localparam logic [3:0] ST_PROG     = 4'd10;
	localparam logic [3:0] ST_DONE     = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		ctl.ld_in     = 1'b0;
		ctl.op        = OP_NONE;
		ctl.div_start = 1'b0;
		ctl.ld_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.ld_in = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!stat.cmd_tick) begin
					ctl.op  = OP_START;
					state_d = ST_DONE;
				end else if (!stat.running) begin
					state_d = ST_DONE;
				end else if (stat.finished) begin
					ctl.op  = OP_SNAP;
					state_d = ST_DONE;
				end else begin
					ctl.op        = OP_M_TEN;
					ctl.div_start = 1'b1;
					state_d       = ST_M_DAMP;
				end
			end
			ST_M_DAMP: begin
				ctl.op  = OP_M_DAMP;
				state_d = ST_ACCEL;
			end
			ST_ACCEL: begin
				ctl.op  = OP_ACCEL;
				state_d = ST_M_ACC;
			end
			ST_M_ACC: begin
				ctl.op  = OP_M_ACC;
				state_d = ST_SPEED;
			end
			ST_SPEED: begin
				ctl.op  = OP_SPEED;
				state_d = ST_M_SPD;
			end
			ST_M_SPD: begin
				ctl.op  = OP_M_SPD;
				state_d = ST_VALUE;
			end
			ST_VALUE: begin
				ctl.op  = OP_VALUE;
				state_d = ST_WAIT_DIV;
			end
			ST_WAIT_DIV: begin
				if (!stat.div_busy) begin
					ctl.op  = OP_M_TT;
					state_d = ST_M_SMOOTH;
				end
			end
			ST_M_SMOOTH: begin
				ctl.op  = OP_M_SMOOTH;
				state_d = ST_PROG;
			end
			ST_PROG: begin
				ctl.op  = OP_PROG;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					ctl.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking bench for spring_animation_step: streams start and tick items,
// predicts every result item and checks each one as it leaves the block.
// Depends on spas_pkg and the RTL top level only.
`default_nettype none

module tb;
	import spas_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint VAL_MAX      = 64'sd2147483647;
	localparam longint VAL_MIN      = -VAL_MAX - 1;
	localparam longint SMOOTH_THREE = 64'sd196608;
	localparam int     LONG_HOLD    = 400;
	localparam int     SETTLE_CYCLES = 25;

	typedef struct packed {
		logic        cmd;
		logic [31:0] time_ms;
		logic [31:0] start_value;
		logic [31:0] goal_value;
	} anim_item_t;

	typedef struct packed {
		logic [31:0]       value;
		logic [PROG_W-1:0] progress;
		logic              running;
	} anim_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_index = REG_TENSION;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [95:0]        s_tdata   = '0;
	logic               s_tuser   = CMD_TICK;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [55:0]        m_tdata;

	// Items waiting to be offered and results still owed by the block
	anim_item_t   pending_items[$];
	anim_result_t expected_results[$];
	int           fail_count   = 0;
	int           queued_total = 0;

	// Idling controls set per phase
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;
	int          hold_left     = 0;
	int          tx_gap        = 0;
	int          rx_gap        = 0;
	anim_item_t  drive_item;
	logic [31:0] tgen = '0;

	// Predicted configuration and animation state
	logic [CFG_W-1:0]  cfg_tension  = TENSION_RST;
	logic [CFG_W-1:0]  cfg_damping  = DAMPING_RST;
	logic [CFG_W-1:0]  cfg_duration = DURATION_RST;
	longint            m_value   = 0;
	longint            m_speed   = 0;
	longint            m_goal    = 0;
	logic [31:0]       m_begin   = '0;
	bit                m_running = 1'b0;
	logic [PROG_W-1:0] m_progress = '0;

	spring_animation_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Product with a Q0.16 fraction, rounded to nearest, ties up
	function automatic longint qmul(input longint a, input longint f);
		return (a * f + 64'sd32768) >>> 16;
	endfunction

	function automatic longint sat_value(input longint x);
		if (x > VAL_MAX)
			return VAL_MAX;
		if (x < VAL_MIN)
			return VAL_MIN;
		return x;
	endfunction

	// Advance the predicted animation by one item and queue its result
	function automatic void predict_animation(input anim_item_t it);
		logic [31:0]  elapsed;
		longint       el_l;
		longint       dur_l;
		longint       frac;
		longint       accel;
		longint       eased;
		anim_result_t res;
		if (it.cmd == CMD_START) begin
			m_value    = longint'($signed(it.start_value));
			m_goal     = longint'($signed(it.goal_value));
			m_begin    = it.time_ms;
			m_speed    = 0;
			m_running  = 1'b1;
			m_progress = '0;
		end else if (m_running) begin
			elapsed = it.time_ms - m_begin;
			if (elapsed >= {16'd0, cfg_duration}) begin
				m_value    = m_goal;
				m_progress = ONE_Q16;
				m_running  = 1'b0;
			end else begin
				accel   = qmul(m_goal - m_value, cfg_tension) - qmul(m_speed, cfg_damping);
				m_speed = sat_value(m_speed + qmul(accel, STEP_Q16));
				m_value = sat_value(m_value + qmul(m_speed, STEP_Q16));
				el_l  = elapsed;
				dur_l = cfg_duration;
				frac  = (el_l <<< 16) / dur_l;
				eased = (frac * frac * (SMOOTH_THREE - 2 * frac) + 64'sd2147483648) >>> 32;
				if (eased > 65536)
					eased = 65536;
				m_progress = eased[PROG_W-1:0];
			end
		end
		res.value    = m_value[31:0];
		res.progress = m_progress;
		res.running  = m_running;
		expected_results.push_back(res);
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(4, 1);
		return $urandom_range(60, 10);
	endfunction

	// Extremes, small magnitudes and full-range values
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return 32'h7FFF_FFFF;
		if (r == 1)
			return 32'h8000_0000;
		if (r < 5)
			return 32'($urandom_range(1310720, 0)) - 32'd655360;
		return $urandom;
	endfunction

	task automatic push_item(input logic cmd, input logic [31:0] t,
			input logic [31:0] sv, input logic [31:0] gv);
		anim_item_t it;
		it.cmd         = cmd;
		it.time_ms     = t;
		it.start_value = sv;
		it.goal_value  = gv;
		pending_items.push_back(it);
		queued_total++;
	endtask

	// Mostly whole animations with random content, the rest noise
	task automatic queue_random_items(input int n);
		int     start_count;
		int     step_hi;
		int     adv;
		int     extra;
		int     r;
		longint elapsed_gen;
		start_count = queued_total;
		step_hi = cfg_duration / 12 + 2;
		while (queued_total - start_count < n) begin
			if ($urandom_range(99, 0) < 82) begin
				if ($urandom_range(9, 0) == 0)
					tgen = $urandom;
				else if ($urandom_range(19, 0) == 0)
					tgen = 32'hFFFF_FFFF - $urandom_range(300, 0);
				push_item(CMD_START, tgen, pick_value(), pick_value());
				elapsed_gen = 0;
				for (int k = 0; k < 60; k++) begin
					r = $urandom_range(99, 0);
					if (r < 4) begin
						// restart mid-flight
						push_item(CMD_START, tgen, pick_value(), pick_value());
						elapsed_gen = 0;
					end else if (r < 7) begin
						// time goes back, possibly past the begin time
						tgen = tgen - $urandom_range(1000, 1);
						push_item(CMD_TICK, tgen, $urandom, $urandom);
						break;
					end else begin
						adv = $urandom_range(step_hi, 0);
						tgen = tgen + adv;
						elapsed_gen = elapsed_gen + adv;
						push_item(CMD_TICK, tgen, $urandom, $urandom);
						if (elapsed_gen >= cfg_duration)
							break;
					end
				end
				// ticks while idle repeat the held values
				extra = $urandom_range(2, 0);
				for (int j = 0; j < extra; j++) begin
					tgen = tgen + $urandom_range(40, 0);
					push_item(CMD_TICK, tgen, $urandom, $urandom);
				end
			end else begin
				if ($urandom_range(1, 0) == 0)
					tgen = $urandom;
				else
					tgen = tgen + $urandom_range(50, 0);
				push_item(logic'($urandom_range(1, 0)), tgen, $urandom, $urandom);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TENSION:  cfg_tension  = val;
			REG_DAMPING:  cfg_damping  = val;
			REG_DURATION: cfg_duration = val;
			default: ;
		endcase
	endtask

	// Hold until every queued item has been taken and answered
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] ten, input logic [CFG_W-1:0] damp,
			input logic [CFG_W-1:0] dur, input int n, input bit tx_on, input bit rx_on,
			input bit long_hold);
		write_reg(REG_TENSION, ten);
		write_reg(REG_DAMPING, damp);
		write_reg(REG_DURATION, dur);
		@(negedge clk);
		tx_idle = tx_on;
		rx_idle = rx_on;
		if (long_hold)
			hold_requests++;
		queue_random_items(n);
		drain();
	endtask

	// Offer items from the pending queue, predict each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_animation(drive_item);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					drive_item = pending_items.pop_front();
					s_tdata  <= {drive_item.goal_value, drive_item.start_value,
						drive_item.time_ms};
					s_tuser  <= drive_item.cmd;
					s_tvalid <= 1'b1;
					tx_gap = tx_idle ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each result item against the oldest prediction, pace m_tready
	always @(posedge clk) begin : result_check
		anim_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result item with nothing owed: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.value) begin
						$error("value_out: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata[31:0]));
						fail_count++;
					end
					if (m_tdata[48:32] !== want.progress) begin
						$error("progress_out: expected %0d, got %0d",
							want.progress, m_tdata[48:32]);
						fail_count++;
					end
					if (m_tdata[49] !== want.running) begin
						$error("running_out: expected %0d, got %0d",
							want.running, m_tdata[49]);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle && $urandom_range(3, 0) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items at the reset configuration (duration 300 ms)
		push_item(CMD_TICK,  32'd0,   32'h0000_0000, 32'h0000_0000); // idle after reset
		push_item(CMD_START, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000); // full swing down
		push_item(CMD_TICK,  32'd116, 32'h0, 32'h0);
		push_item(CMD_TICK,  32'd132, 32'h0, 32'h0);
		push_item(CMD_TICK,  32'd148, 32'h0, 32'h0);
		push_item(CMD_TICK,  32'd164, 32'h0, 32'h0);
		push_item(CMD_START, 32'd200, 32'h8000_0000, 32'h7FFF_FFFF); // restart while running
		push_item(CMD_TICK,  32'd216, 32'h0, 32'h0);
		push_item(CMD_TICK,  32'd199, 32'h0, 32'h0);                 // before begin time
		push_item(CMD_TICK,  32'd500, 32'h0, 32'h0);                 // idle, held values
		push_item(CMD_START, 32'd1000, 32'h0000_0000, 32'h0001_0000);
		push_item(CMD_TICK,  32'd1299, 32'h0, 32'h0);                // one short of duration
		push_item(CMD_TICK,  32'd1300, 32'h0, 32'h0);                // exactly at duration
		push_item(CMD_START, 32'hFFFF_FFF0, 32'hFFFB_0000, 32'h0003_0000);
		push_item(CMD_TICK,  32'h0000_0005, 32'h0, 32'h0);           // across the time wrap
		push_item(CMD_TICK,  32'h0000_0100, 32'h0, 32'h0);
		push_item(CMD_START, 32'h1234_5678, 32'h0000_1234, 32'h0000_1234);
		push_item(CMD_TICK,  32'h1234_5678, 32'h0, 32'h0);           // zero elapsed
		push_item(CMD_TICK,  32'h1234_570E, 32'h0, 32'h0);           // half way
		push_item(CMD_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(CMD_TICK,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Out-of-range index must leave every register alone
		write_reg(REG_UNUSED, CFG_W'($urandom));

		run_phase(16'hFFFF, 16'h0000, 16'd300, 250, 1'b1, 1'b1, 1'b1);
		run_phase(16'h0000, 16'hFFFF, 16'd1, 150, 1'b0, 1'b0, 1'b0);
		run_phase(CFG_W'($urandom), CFG_W'($urandom), 16'd0, 150, 1'b1, 1'b1, 1'b0);
		run_phase(CFG_W'($urandom), CFG_W'($urandom), 16'hFFFF, 200, 1'b1, 1'b0, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, CFG_W'($urandom_range(1000, 1)), 190,
			1'b0, 1'b1, 1'b1);
		for (int p = 0; p < 4; p++) begin
			run_phase(CFG_W'($urandom), CFG_W'($urandom),
				($urandom_range(3, 0) != 0) ? CFG_W'($urandom_range(1000, 1))
					: CFG_W'($urandom),
				190, bit'($urandom_range(1, 0)), bit'($urandom_range(1, 0)), 1'b0);
		end

		// Let any stray result item show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/spas_pkg.sv
rtl/spas_div.sv
rtl/spas_dp.sv
rtl/spas_ctrl.sv
rtl/spring_animation_step.sv
dv/tb.sv
